// ===== src/spba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spba_pkg
// Shared types, constants and helpers of the segregated pool block allocator.
// ----------------------------------------------------------------------------
package spba_pkg;

  localparam int POOL_COUNT        = 8;
  localparam int POOL_IDX_W        = 3;
  localparam int SLOTS_PER_POOL    = 1024;
  localparam int SLOT_W            = 10;
  localparam int LINK_W            = 11;
  localparam int POOL_BYTES_LOG2   = 24;
  localparam int HEADER_BYTES_LOG2 = 12;
  localparam int ADDR_W            = 27;
  localparam int BYTES_W           = 24;
  localparam int ALIGN_W           = 5;
  localparam int CNT_W             = 11;
  localparam int LINK_ADDR_W       = POOL_IDX_W + SLOT_W;
  localparam int DIV_STEPS         = SLOT_W;

  localparam logic [LINK_W-1:0] LINK_NONE = '1;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_REQ  = 2'd2,
    ST_NOT_LIVE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_SCAN_RD,
    S_SCAN_CK,
    S_TAKE,
    S_LINK,
    S_MUL,
    S_ADDR,
    S_META,
    S_FCHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [BYTES_W-1:0] size_bytes;
    logic [ALIGN_W-1:0] align;
    logic [BYTES_W-1:0] stride;
    logic [CNT_W-1:0]   capacity;
    logic [CNT_W-1:0]   in_use;
    logic [CNT_W-1:0]   high_water;
    logic [LINK_W-1:0]  head;
  } pool_meta_t;

  // Offset of the first block: max(header size, alignment).
  function automatic logic [BYTES_W-1:0] first_offset(input logic [ALIGN_W-1:0] alog);
    logic [BYTES_W-1:0] al;
    al = BYTES_W'(1) << alog;
    if (alog > ALIGN_W'(HEADER_BYTES_LOG2))
      return al;
    else
      return BYTES_W'(1) << HEADER_BYTES_LOG2;
  endfunction

endpackage

// ===== src/segregated_pool_block_allocator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segregated_pool_block_allocator_unit
// Fixed-size block allocator over size-aligned pools; metadata and free-list
// links live in synchronous RAMs.
// ----------------------------------------------------------------------------
// Channel | Dir | tdata                                   | tuser
// s_*     | in  | block_bytes, align_log2, block_address | opcode
// m_*     | out | result_address, result_bytes           | status
//
// Sequencing: one request at a time; the next word is taken the cycle after the
// result is loaded. Allocate: decode, restoring division for the capacity
// (skipped when capacity caps at 1024), a read-and-check scan of the pools,
// then pop a slot, form the address and load the result. Free divides the
// offset by the stride, then checks and pushes the slot; query reads metadata.
// Allocate time is set by the bit-serial divider and the pool scan.
// Reset: rst clears the pool live bits and the sequencer; RAMs are not swept.
// Stalls: a new word is taken while a result waits on m_*; the unit holds in
// its final state only if a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module segregated_pool_block_allocator_unit
  import spba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [23:0] block_bytes, [28:24] align_log2, [55:29] block_address
  input  logic [55:0] s_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [26:0] result_address, [50:27] result_bytes
  output logic [55:0] m_tdata,
  // [1:0] status
  output logic [1:0]  m_tuser
);

  state_t state, state_next;

  // request
  logic [1:0]         op;
  logic [BYTES_W-1:0] req_bytes;
  logic [ALIGN_W-1:0] req_alog;
  logic [ADDR_W-1:0]  req_addr;

  // working registers
  logic [POOL_COUNT-1:0]   live;
  logic [POOL_IDX_W-1:0]   pool;
  logic [POOL_IDX_W-1:0]   scan_idx;
  pool_meta_t              meta;
  logic [BYTES_W:0]        stride;
  logic [BYTES_W:0]        rem;
  logic [CNT_W-1:0]        quo;
  logic [3:0]              div_cnt;
  logic [SLOT_W-1:0]       slot;
  logic [BYTES_W+SLOT_W-1:0] prod;

  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [BYTES_W-1:0] res_bytes;

  // metadata RAM
  pool_meta_t            meta_mem [POOL_COUNT];
  pool_meta_t            meta_q;
  pool_meta_t            meta_wdata;
  logic [POOL_IDX_W-1:0] meta_raddr;
  logic                  meta_we;

  // free-list link RAM
  logic [LINK_W-1:0]      link_mem [POOL_COUNT*SLOTS_PER_POOL];
  logic [LINK_W-1:0]      link_q;
  logic [LINK_ADDR_W-1:0] link_raddr;
  logic                   link_we;
  logic [LINK_ADDR_W-1:0] link_waddr;

  // decode helpers
  logic [BYTES_W:0]        al;
  logic [BYTES_W:0]        stride_calc;
  logic [BYTES_W-1:0]      first_calc;
  logic [BYTES_W:0]        cap_num;
  logic [POOL_IDX_W-1:0]   req_pool;
  logic                    req_pool_ok;
  logic [BYTES_W-1:0]      off;
  logic [BYTES_W-1:0]      meta_first;
  logic [BYTES_W+DIV_STEPS:0] den_sh;
  logic                    scan_hit;
  logic                    any_free;
  logic [POOL_IDX_W-1:0]   free_pool;
  logic                    out_load;

  assign req_pool    = req_addr[ADDR_W-1:POOL_BYTES_LOG2];
  assign req_pool_ok = ({1'b0, req_pool} < (POOL_IDX_W+1)'(POOL_COUNT)) && live[req_pool];
  assign off         = req_addr[POOL_BYTES_LOG2-1:0];
  assign al          = (BYTES_W+1)'(1) << req_alog;
  assign stride_calc = ({1'b0, req_bytes} + al - (BYTES_W+1)'(1)) & ~(al - (BYTES_W+1)'(1));
  assign first_calc  = first_offset(req_alog);
  assign cap_num     = ((BYTES_W+1)'(1) << POOL_BYTES_LOG2) - {1'b0, first_calc};
  assign meta_first  = first_offset(meta_q.align);
  assign den_sh      = (BYTES_W+DIV_STEPS+1)'(stride) << div_cnt;

  assign scan_hit = live[scan_idx] && meta_q.size_bytes == req_bytes &&
                    meta_q.align == req_alog && meta_q.in_use < meta_q.capacity &&
                    (meta_q.head != LINK_NONE || meta_q.high_water < meta_q.capacity);

  // lowest unused pool
  always_comb begin
    any_free  = 1'b0;
    free_pool = '0;
    for (int i = POOL_COUNT-1; i >= 0; i--) begin
      if (!live[i]) begin
        any_free  = 1'b1;
        free_pool = POOL_IDX_W'(i);
      end
    end
  end

  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // next state and strobes
  always_comb begin
    state_next = state;
    meta_raddr = scan_idx;
    link_raddr = {pool, meta.head[SLOT_W-1:0]};
    meta_we    = 1'b0;
    meta_wdata = meta;
    link_we    = 1'b0;
    link_waddr = {pool, quo[SLOT_W-1:0]};
    unique case (state)
      S_IDLE:    if (s_tvalid) state_next = S_DECODE;
      S_DECODE: begin
        meta_raddr = req_pool;
        priority if (op == OP_ALLOC) begin
          if (req_bytes == '0 || req_alog >= ALIGN_W'(POOL_BYTES_LOG2))
            state_next = S_DONE;
          else if ((cap_num >> SLOT_W) >= stride_calc)
            state_next = S_SCAN_RD;
          else
            state_next = S_DIV;
        end else if (op == OP_FREE || op == OP_QUERY) begin
          state_next = req_pool_ok ? S_META : S_DONE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        if (div_cnt == '0) begin
          if (op == OP_FREE) state_next = S_FCHK;
          else state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (op == OP_ALLOC && quo == '0) state_next = S_DONE;
        else state_next = S_SCAN_CK;
      end
      S_SCAN_CK: begin
        if (scan_hit) state_next = S_TAKE;
        else if (scan_idx == POOL_IDX_W'(POOL_COUNT-1))
          state_next = any_free ? S_TAKE : S_DONE;
        else state_next = S_SCAN_RD;
      end
      S_TAKE:    state_next = (meta.head != LINK_NONE) ? S_LINK : S_MUL;
      S_LINK:    state_next = S_MUL;
      S_MUL:     state_next = S_ADDR;
      S_ADDR: begin
        meta_we    = 1'b1;
        state_next = S_DONE;
      end
      S_META: begin
        if (op == OP_QUERY) state_next = S_DONE;
        else if (off < meta_first || meta_q.stride == '0 || meta_q.in_use == '0)
          state_next = S_DONE;
        else if (((off - meta_first) >> SLOT_W) >= meta_q.stride)
          state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_FCHK: begin
        if (rem == '0 && quo < meta.high_water) begin
          // push the slot: new head, one fewer in use
          meta_we           = 1'b1;
          meta_wdata.head   = quo;
          meta_wdata.in_use = meta.in_use - CNT_W'(1);
          link_we           = 1'b1;
        end
        state_next = S_DONE;
      end
      S_DONE:    if (out_load) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // RAMs
  always_ff @(posedge clk) begin
    meta_q <= meta_mem[meta_raddr];
    if (meta_we) meta_mem[pool] <= meta_wdata;
  end

  always_ff @(posedge clk) begin
    link_q <= link_mem[link_raddr];
    if (link_we) link_mem[link_waddr] <= meta.head;
  end

  // live bits
  always_ff @(posedge clk) begin
    if (rst) live <= '0;
    else if (state == S_ADDR) live[pool] <= 1'b1;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op        <= s_tuser;
          req_bytes <= s_tdata[23:0];
          req_alog  <= s_tdata[28:24];
          req_addr  <= s_tdata[55:29];
        end
        res_status <= ST_BAD_REQ;
        res_addr   <= '0;
        res_bytes  <= '0;
      end
      S_DECODE: begin
        stride   <= stride_calc;
        rem      <= cap_num;
        quo      <= CNT_W'(SLOTS_PER_POOL);
        div_cnt  <= 4'(DIV_STEPS-1);
        scan_idx <= '0;
        pool     <= req_pool;
        if (op == OP_ALLOC) begin
          if ((cap_num >> SLOT_W) < stride_calc) quo <= '0;
        end else if (op == OP_FREE || op == OP_QUERY) begin
          if (!req_pool_ok) res_status <= ST_NOT_LIVE;
        end
      end
      S_DIV: begin
        if (den_sh <= (BYTES_W+DIV_STEPS+1)'(rem)) begin
          rem          <= rem - den_sh[BYTES_W:0];
          quo[div_cnt] <= 1'b1;
        end
        div_cnt <= div_cnt - 4'd1;
      end
      S_SCAN_RD: ;
      S_SCAN_CK: begin
        if (scan_hit) begin
          pool <= scan_idx;
          meta <= meta_q;
        end else if (scan_idx == POOL_IDX_W'(POOL_COUNT-1)) begin
          if (any_free) begin
            pool            <= free_pool;
            meta.size_bytes <= req_bytes;
            meta.align      <= req_alog;
            meta.stride     <= stride[BYTES_W-1:0];
            meta.capacity   <= quo;
            meta.in_use     <= '0;
            meta.high_water <= '0;
            meta.head       <= LINK_NONE;
          end else begin
            res_status <= ST_NO_SPACE;
          end
        end else begin
          scan_idx <= scan_idx + POOL_IDX_W'(1);
        end
      end
      S_TAKE: begin
        if (meta.head == LINK_NONE) begin
          slot            <= meta.high_water[SLOT_W-1:0];
          meta.high_water <= meta.high_water + CNT_W'(1);
          meta.in_use     <= meta.in_use + CNT_W'(1);
        end
      end
      S_LINK: begin
        slot        <= meta.head[SLOT_W-1:0];
        meta.head   <= link_q;
        meta.in_use <= meta.in_use + CNT_W'(1);
      end
      S_MUL:  prod <= slot * meta.stride;
      S_ADDR: begin
        res_status <= ST_OK;
        res_addr   <= ADDR_W'({pool, {POOL_BYTES_LOG2{1'b0}}}) +
                      ADDR_W'(first_offset(meta.align)) + ADDR_W'(prod);
      end
      S_META: begin
        meta   <= meta_q;
        stride <= {1'b0, meta_q.stride};
        rem    <= {1'b0, off - meta_first};
        quo    <= '0;
        if (op == OP_QUERY) begin
          res_status <= ST_OK;
          res_bytes  <= meta_q.size_bytes;
        end
      end
      S_FCHK: begin
        if (rem == '0 && quo < meta.high_water) begin
          res_status  <= ST_OK;
          meta.head   <= quo;
          meta.in_use <= meta.in_use - CNT_W'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= {5'b0, res_bytes, res_addr};
    end
  end

  // checks
  a_claim_live: assert property (@(posedge clk) disable iff (rst)
    state == S_ADDR |=> live[$past(pool)])
    else $error("pool not live after allocate");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
    else $error("error result carries data");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DECODE)
    else $error("accepted word not decoded");

  a_one_write_place: assert property (@(posedge clk) disable iff (rst)
    link_we |-> meta_we && op == OP_FREE)
    else $error("link write outside free");

endmodule
